/* hdl/mtt_pkg.sv */
// Package with the shared constants, codes and types of the max tournament tree.
package mtt_pkg;

    localparam int DEFAULT_LEVELS      = 6;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int CMD_WIDTH           = 2;
    localparam int STATUS_WIDTH        = 2;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLIMB,
        S_FINISH
    } state_t;

endpackage

/* hdl/mtt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/max_tournament_tree_unit.sv */
// Top level of the max tournament tree: slot occupancy, tree replay and result stage.
//
// Input beats carry a command in s_axis_tuser and its operands in s_axis_tdata.
// An insert places the value in the lowest empty slot, a delete empties the
// given slot, and a query changes nothing. Every beat returns one result
// beat with the current maximum, its slot, the slot given to an insert and a
// status code.
// An insert or delete replays the path from the slot to the root, one tree
// level per cycle through a winner memory with one read port: the input beat
// is taken in S_IDLE, then S_CLIMB steps up the tree level by level, and the
// result is loaded on the last level if the output register is free, else in
// S_FINISH; the unit then returns to S_IDLE to take the next beat. A query, a
// full-tree insert or a delete of an empty slot goes straight to S_FINISH.
// Reset empties every slot at once through occupancy flags; no clearing pass
// is needed. When the receiver stalls, the result stays in the output
// register and the next beat is still taken and processed; it then waits
// with its result until the output register is free.
module max_tournament_tree_unit #(
    parameter int LEVELS      = mtt_pkg::DEFAULT_LEVELS,
    parameter int VALUE_WIDTH = mtt_pkg::DEFAULT_VALUE_WIDTH,
    localparam int InBits     = VALUE_WIDTH + LEVELS,
    localparam int InW        = ((InBits + 7) / 8) * 8,
    localparam int OutBits    = 1 + VALUE_WIDTH + 2 * LEVELS,
    localparam int OutW       = ((OutBits + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: item_value, slot.
    input  logic [InW-1:0]                  s_axis_tdata,
    // Fields from bit 0: cmd.
    input  logic [mtt_pkg::CMD_WIDTH-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: max_valid, max_value, max_slot, insert_slot.
    output logic [OutW-1:0]                 m_axis_tdata,
    // Fields from bit 0: status.
    output logic [mtt_pkg::STATUS_WIDTH-1:0] m_axis_tuser
);

    import mtt_pkg::*;

    localparam int LEAVES = 2 ** LEVELS;
    localparam int NODES  = LEAVES - 1;
    localparam int NAW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int NW     = LEVELS + 1;
    localparam int WW     = LEVELS + VALUE_WIDTH;

    function automatic logic [LEVELS-1:0] lowest_free(input logic [LEAVES-1:0] used);
        logic [LEVELS-1:0] r;
        r = '0;
        for (int i = LEAVES - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                r = LEVELS'(i);
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [LW-1:0]          lvl_reg, lvl_next;
    logic [LEVELS-1:0]      slot_reg, slot_next;
    logic                   path_used_reg, path_used_next;
    logic [LEVELS-1:0]      path_slot_reg, path_slot_next;
    logic [VALUE_WIDTH-1:0] path_val_reg, path_val_next;
    logic [LEVELS-1:0]      res_ins_reg, res_ins_next;
    status_t                res_status_reg, res_status_next;
    logic [LEAVES-1:0]      leaf_used_reg, leaf_used_next;
    logic [NODES-1:0]       win_used_reg, win_used_next;
    logic [VALUE_WIDTH-1:0] root_val_reg, root_val_next;
    logic [LEVELS-1:0]      root_slot_reg, root_slot_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   o_valid_reg, o_valid_next;
    logic [VALUE_WIDTH-1:0] o_val_reg, o_val_next;
    logic [LEVELS-1:0]      o_slot_reg, o_slot_next;
    logic [LEVELS-1:0]      o_ins_reg, o_ins_next;
    status_t                o_status_reg, o_status_next;

    logic                   accept;
    logic [CMD_WIDTH-1:0]   in_cmd;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [LEVELS-1:0]      in_slot;
    logic [LEVELS-1:0]      free_slot;
    logic                   full;

    logic                   leaf_we;
    logic [LEVELS-1:0]      leaf_raddr;
    logic [VALUE_WIDTH-1:0] leaf_rdata;
    logic                   win_we;
    logic [NAW-1:0]         win_waddr;
    logic [WW-1:0]          win_wdata;
    logic [NAW-1:0]         win_raddr;
    logic [WW-1:0]          win_rdata;

    logic [NW-1:0]          leaf_node;
    logic [NW-1:0]          path_child;
    logic [NW-1:0]          parent;
    logic [NW-1:0]          sib_node;
    logic [NW-1:0]          next_sib;
    logic                   last_lvl;
    logic                   sib_used;
    logic [LEVELS-1:0]      sib_slot;
    logic [VALUE_WIDTH-1:0] sib_val;
    logic                   lu, ru, left_wins;
    logic [LEVELS-1:0]      ls, rs;
    logic [VALUE_WIDTH-1:0] lv, rv;
    logic                   w_used;
    logic [LEVELS-1:0]      w_slot;
    logic [VALUE_WIDTH-1:0] w_val;
    logic                   load_out;

    assign in_cmd    = s_axis_tuser;
    assign in_val    = s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_slot   = s_axis_tdata[VALUE_WIDTH +: LEVELS];
    assign free_slot = lowest_free(leaf_used_reg);
    assign full      = &leaf_used_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign leaf_node  = {1'b1, slot_reg};
    assign path_child = leaf_node >> lvl_reg;
    assign parent     = path_child >> 1;
    assign sib_node   = path_child ^ NW'(1);
    assign next_sib   = (leaf_node >> ({1'b0, lvl_reg} + (LW + 1)'(1))) ^ NW'(1);
    assign last_lvl   = (lvl_reg == LW'(LEVELS - 1));

    always_comb
    begin
        if (lvl_reg == '0)
        begin
            sib_used = leaf_used_reg[slot_reg ^ LEVELS'(1)];
            sib_slot = slot_reg ^ LEVELS'(1);
            sib_val  = leaf_rdata;
        end
        else
        begin
            sib_used = win_used_reg[NAW'(sib_node - NW'(1))];
            sib_slot = win_rdata[VALUE_WIDTH +: LEVELS];
            sib_val  = win_rdata[VALUE_WIDTH-1:0];
        end

        if (!path_child[0])
        begin
            lu = path_used_reg;
            ls = path_slot_reg;
            lv = path_val_reg;
            ru = sib_used;
            rs = sib_slot;
            rv = sib_val;
        end
        else
        begin
            lu = sib_used;
            ls = sib_slot;
            lv = sib_val;
            ru = path_used_reg;
            rs = path_slot_reg;
            rv = path_val_reg;
        end

        left_wins = lu && (!ru || ($signed(lv) >= $signed(rv)));
        w_used    = lu || ru;
        if (left_wins)
        begin
            w_slot = ls;
            w_val  = lv;
        end
        else if (ru)
        begin
            w_slot = rs;
            w_val  = rv;
        end
        else
        begin
            w_slot = '0;
            w_val  = '0;
        end
    end

    assign win_we    = (state_reg == S_CLIMB);
    assign win_waddr = NAW'(parent - NW'(1));
    assign win_wdata = {w_slot, w_val};
    assign win_raddr = NAW'(next_sib - NW'(1));

    assign leaf_we    = accept && (in_cmd == CMD_INSERT) && !full;
    assign leaf_raddr = ((in_cmd == CMD_INSERT) ? free_slot : in_slot) ^ LEVELS'(1);

    mtt_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LEAVES)
    ) u_leaf_ram (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (free_slot),
        .wdata (in_val),
        .raddr (leaf_raddr),
        .rdata (leaf_rdata)
    );

    mtt_ram #(
        .WIDTH (WW),
        .DEPTH (NODES)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            leaf_used_reg <= '0;
            win_used_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            leaf_used_reg <= leaf_used_next;
            win_used_reg  <= win_used_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        path_used_reg  <= path_used_next;
        path_slot_reg  <= path_slot_next;
        path_val_reg   <= path_val_next;
        res_ins_reg    <= res_ins_next;
        res_status_reg <= res_status_next;
        root_val_reg   <= root_val_next;
        root_slot_reg  <= root_slot_next;
        o_valid_reg    <= o_valid_next;
        o_val_reg      <= o_val_next;
        o_slot_reg     <= o_slot_next;
        o_ins_reg      <= o_ins_next;
        o_status_reg   <= o_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        slot_next       = slot_reg;
        path_used_next  = path_used_reg;
        path_slot_next  = path_slot_reg;
        path_val_next   = path_val_reg;
        res_ins_next    = res_ins_reg;
        res_status_next = res_status_reg;
        leaf_used_next  = leaf_used_reg;
        win_used_next   = win_used_reg;
        root_val_next   = root_val_reg;
        root_slot_next  = root_slot_reg;
        load_out        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    lvl_next        = '0;
                    res_ins_next    = '0;
                    res_status_next = ST_OK;
                    path_val_next   = in_val;
                    state_next      = S_FINISH;
                    unique case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                slot_next                 = free_slot;
                                path_used_next            = 1'b1;
                                path_slot_next            = free_slot;
                                res_ins_next              = free_slot;
                                leaf_used_next[free_slot] = 1'b1;
                                state_next                = S_CLIMB;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (!leaf_used_reg[in_slot])
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                slot_next               = in_slot;
                                path_used_next          = 1'b0;
                                path_slot_next          = in_slot;
                                leaf_used_next[in_slot] = 1'b0;
                                state_next              = S_CLIMB;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_CLIMB:
            begin
                win_used_next[NAW'(parent - NW'(1))] = w_used;
                path_used_next = w_used;
                path_slot_next = w_slot;
                path_val_next  = w_val;
                lvl_next       = lvl_reg + LW'(1);
                if (last_lvl)
                begin
                    root_val_next  = w_val;
                    root_slot_next = w_slot;
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        o_valid_next  = o_valid_reg;
        o_val_next    = o_val_reg;
        o_slot_next   = o_slot_reg;
        o_ins_next    = o_ins_reg;
        o_status_next = o_status_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        if (load_out)
        begin
            m_valid_next  = 1'b1;
            o_ins_next    = res_ins_reg;
            o_status_next = res_status_reg;
            if (state_reg == S_CLIMB)
            begin
                o_valid_next = w_used;
                o_val_next   = w_used ? w_val : '0;
                o_slot_next  = w_used ? w_slot : '0;
            end
            else
            begin
                o_valid_next = win_used_reg[0];
                o_val_next   = win_used_reg[0] ? root_val_reg : '0;
                o_slot_next  = win_used_reg[0] ? root_slot_reg : '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OutW'({o_ins_reg, o_slot_reg, o_val_reg, o_valid_reg});
    assign m_axis_tuser  = o_status_reg;

`ifndef SYNTHESIS
    a_root_tracks_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (win_used_reg[0] == (|leaf_used_reg)))
        else $error("root occupancy disagrees with leaf occupancy");

    a_climb_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLIMB && last_lvl) |=> (state_reg != S_CLIMB))
        else $error("replay runs past the root");

    a_insert_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == CMD_INSERT && !full) |=> leaf_used_reg[$past(free_slot)])
        else $error("inserted slot not marked as used");

    a_delete_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == CMD_DELETE && leaf_used_reg[in_slot])
        |=> !leaf_used_reg[$past(in_slot)])
        else $error("deleted slot still marked as used");
`endif

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the max tournament tree unit with its own occupancy-scan predictor.
`timescale 1ns / 100ps

module tb_top;

    import mtt_pkg::*;

    localparam int LEAVES = 1 << DEFAULT_LEVELS;
    localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                 max_valid;
        logic signed [31:0]   max_value;
        logic [5:0]           max_slot;
        logic [5:0]           insert_slot;
        status_t              status;
    } max_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic [CMD_WIDTH-1:0]  s_axis_tuser = CMD_QUERY;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic [STATUS_WIDTH-1:0] m_axis_tuser;

    logic signed [31:0]    slot_value [LEAVES];
    bit                    slot_busy [LEAVES];
    max_result_t           expected_results [$];
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    mismatches = 0;
    int                    results_seen = 0;

    max_tournament_tree_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // The root winner of a left-biased tree is the leftmost occupied slot holding the largest value.
    function automatic max_result_t apply_command(input logic [1:0] op,
                                                  input logic signed [31:0] value,
                                                  input logic [5:0] target);
        max_result_t r;
        bit          found;
        r.max_valid   = 1'b0;
        r.max_value   = '0;
        r.max_slot    = '0;
        r.insert_slot = '0;
        r.status      = ST_OK;
        found = 1'b0;
        case (op)
            CMD_INSERT:
            begin
                for (int i = 0; i < LEAVES && !found; i++)
                begin
                    if (!slot_busy[i])
                    begin
                        found         = 1'b1;
                        slot_busy[i]  = 1'b1;
                        slot_value[i] = value;
                        r.insert_slot = i[5:0];
                    end
                end
                if (!found)
                    r.status = ST_FULL;
            end
            CMD_DELETE:
            begin
                if (slot_busy[target])
                    slot_busy[target] = 1'b0;
                else
                    r.status = ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < LEAVES; i++)
        begin
            if (slot_busy[i] && (!r.max_valid || slot_value[i] > r.max_value))
            begin
                r.max_valid = 1'b1;
                r.max_value = slot_value[i];
                r.max_slot  = i[5:0];
            end
        end
        return r;
    endfunction

    function automatic int occupied_count();
        int n;
        n = 0;
        for (int i = 0; i < LEAVES; i++)
            n += slot_busy[i];
        return n;
    endfunction

    function automatic logic [5:0] random_busy_slot();
        int n;
        int pick;
        n = occupied_count();
        if (n == 0)
            return 6'($urandom);
        pick = $urandom_range(n - 1);
        for (int i = 0; i < LEAVES; i++)
        begin
            if (slot_busy[i])
            begin
                if (pick == 0)
                    return i[5:0];
                pick--;
            end
        end
        return '0;
    endfunction

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1: return 32'($signed($urandom_range(8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic signed [31:0] value,
                             input logic [5:0] target);
        max_result_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, target, value};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = apply_command(op, value, target);
        expected_results.insert(expected_results.size(), want);
        @(negedge clk);
    endtask

    task automatic note_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("result %0d, %s: expected %0d, got %0d", results_seen, field, want, got);
    endtask

    always @(posedge clk)
    begin
        max_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                note_mismatch("unexpected beat", 0, 1);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[0] !== want.max_valid)
                    note_mismatch("max_valid", want.max_valid, m_axis_tdata[0]);
                if ($signed(m_axis_tdata[32:1]) !== want.max_value)
                    note_mismatch("max_value", want.max_value, $signed(m_axis_tdata[32:1]));
                if (m_axis_tdata[38:33] !== want.max_slot)
                    note_mismatch("max_slot", want.max_slot, m_axis_tdata[38:33]);
                if (m_axis_tdata[44:39] !== want.insert_slot)
                    note_mismatch("insert_slot", want.insert_slot, m_axis_tdata[44:39]);
                if (m_axis_tuser !== want.status)
                    note_mismatch("status", want.status, m_axis_tuser);
            end
        end
    end

    task automatic test_directed();
        send_beat(CMD_QUERY, 32'sh12345678, 6'd9);
        send_beat(CMD_UNUSED, 32'sh7fffffff, 6'd63);
        send_beat(CMD_DELETE, 32'sd0, 6'd0);
        send_beat(CMD_DELETE, 32'sd0, 6'd63);
        send_beat(CMD_INSERT, 32'sh7fffffff, 6'd63);
        send_beat(CMD_INSERT, 32'sh80000000, 6'd0);
        send_beat(CMD_INSERT, 32'sd0, 6'd42);
        send_beat(CMD_INSERT, -32'sd1, 6'd21);
        send_beat(CMD_INSERT, 32'sh7fffffff, 6'd0);
        send_beat(CMD_DELETE, 32'sh55555555, 6'd0);
        send_beat(CMD_INSERT, 32'sd5, 6'd0);
        send_beat(CMD_DELETE, 32'sd0, 6'd4);
        send_beat(CMD_DELETE, 32'sd0, 6'd1);
        send_beat(CMD_DELETE, 32'sd0, 6'd1);
        send_beat(CMD_UNUSED, 32'sd7, 6'd2);
        send_beat(CMD_DELETE, 32'sd0, 6'd40);
        send_beat(CMD_DELETE, 32'sd0, 6'd0);
        send_beat(CMD_DELETE, 32'sd0, 6'd2);
        send_beat(CMD_DELETE, 32'shaaaaaaaa, 6'd3);
        send_beat(CMD_QUERY, 32'sd0, 6'd0);
    endtask

    task automatic test_full_tree();
        for (int i = 0; i < LEAVES; i++)
            send_beat(CMD_INSERT, 32'($signed($urandom_range(6)) - 3), 6'($urandom));
        for (int i = 0; i < 3; i++)
            send_beat(CMD_INSERT, random_value(), 6'($urandom));
        send_beat(CMD_DELETE, 32'($urandom), 6'd63);
        send_beat(CMD_DELETE, 32'($urandom), 6'd17);
        send_beat(CMD_DELETE, 32'($urandom), 6'd0);
        for (int i = 0; i < 4; i++)
            send_beat(CMD_INSERT, random_value(), 6'($urandom));
        while (occupied_count() != 0)
            send_beat(CMD_DELETE, 32'($urandom), random_busy_slot());
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count,
                                     input int insert_pct);
        int roll;
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < insert_pct)
                send_beat(CMD_INSERT, random_value(), 6'($urandom));
            else if (roll < 88)
                send_beat(CMD_DELETE, 32'($urandom),
                          ($urandom_range(9) == 0) ? 6'($urandom) : random_busy_slot());
            else if (roll < 96)
                send_beat(CMD_QUERY, 32'($urandom), 6'($urandom));
            else
                send_beat(CMD_UNUSED, 32'($urandom), 6'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_value[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        idle_pct  = 23;
        stall_pct = 23;
        test_full_tree();
        test_random_phase(0, 0, 500, 62);
        test_random_phase(75, 0, 500, 45);
        test_random_phase(0, 75, 500, 58);
        test_random_phase(23, 23, 500, 40);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hdl/mtt_pkg.sv
hdl/mtt_ram.sv
hdl/max_tournament_tree_unit.sv
sim/tb_top.sv
